/* hw/rtl/particle_sensor_frame_parser_defines.svh */
// ---------------------------------------------------------------------------
// Particle sensor frame parser: assertion macros
// Small wrappers around concurrent assertions clocked on clk and disabled
// while rst is high. Defining NO_ASSERTIONS removes them all.
// ---------------------------------------------------------------------------
`ifndef PARTICLE_SENSOR_FRAME_PARSER_DEFINES_SVH
`define PARTICLE_SENSOR_FRAME_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The property must hold in the same cycle as the condition.
`define PSFP_ASSERT_SAME(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("particle sensor frame parser: same-cycle check failed");

// The property must hold in the cycle after the condition.
`define PSFP_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("particle sensor frame parser: next-cycle check failed");

`else

`define PSFP_ASSERT_SAME(label, cond, prop)
`define PSFP_ASSERT_NEXT(label, cond, prop)

`endif

`endif

/* hw/rtl/psfp_pkg.sv */
// ---------------------------------------------------------------------------
// Particle sensor frame parser package
// Shared types and fixed constants of the frame parser.
// ---------------------------------------------------------------------------
`default_nettype none

package psfp_pkg;

  // Byte that opens every frame.
  localparam logic [7:0] START_BYTE = 8'h42;

  // At most this many data words are sent for one frame.
  localparam int MAX_WORDS = 14;

  // Width of the word index on the result channel.
  localparam int INDEX_W = 4;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_FRAME,
    ST_READ_HI,
    ST_READ_LO,
    ST_LOAD
  } psfp_state_t;

endpackage

`default_nettype wire

/* hw/rtl/psfp_ram.sv */
// ---------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered and holds
// its value in cycles without a read.
// ---------------------------------------------------------------------------
`default_nettype none

module psfp_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/particle_sensor_frame_parser.sv */
// ---------------------------------------------------------------------------
// Particle sensor frame parser
// Hunts for the start byte in a serial byte stream, stores one frame in a
// small RAM while summing it, and then sends the frame's data words.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   input    in         in_valid / in_stall    rx_byte
//   result   out        out_valid / out_stall  word_index, word_value,
//                                              checksum_ok, last_word
//
// A frame of FRAME_BYTES bytes needs FRAME_BYTES input transactions. After
// the final byte the block reads the stored frame back through the single
// RAM read port, two reads per word, high byte then low byte, and loads each
// word into the output register once that register is free; a stalled
// receiver holds the read-out. The input is stalled while the words are
// being read out. Reset is synchronous and returns the block to hunting;
// the RAM needs no clearing.
// ---------------------------------------------------------------------------
`default_nettype none

`include "particle_sensor_frame_parser_defines.svh"

module particle_sensor_frame_parser
  import psfp_pkg::*;
#(
  parameter int FRAME_BYTES = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // Byte input
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [7:0]         rx_byte,
  // Word results
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic [INDEX_W-1:0] word_index,
  output      logic [15:0]        word_value,
  output      logic               checksum_ok,
  output      logic               last_word
);

  // Address width of the frame store; FRAME_BYTES - 1 is the largest count
  // held between bytes, so the count shares this width.
  localparam int AW        = $clog2(FRAME_BYTES);
  localparam int RAW_WORDS = (FRAME_BYTES - 4) / 2;
  localparam int NWORDS    = (RAW_WORDS > MAX_WORDS) ? MAX_WORDS : RAW_WORDS;

  localparam logic [AW-1:0]      IDX_CHK_HI = AW'(FRAME_BYTES - 2);
  localparam logic [AW-1:0]      IDX_LAST   = AW'(FRAME_BYTES - 1);
  localparam logic [INDEX_W-1:0] LAST_WORD  = INDEX_W'(NWORDS - 1);

  psfp_state_t        state;
  psfp_state_t        state_next;

  logic [AW-1:0]      byte_count;
  logic [15:0]        running_sum;
  logic [7:0]         chk_hi;
  logic               sum_ok;
  logic [INDEX_W-1:0] word_cnt;
  logic [7:0]         hi_byte;

  logic               in_fire;
  logic               out_fire;
  logic               load_ok;
  logic               is_last;
  logic [4:0]         pair_addr;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [7:0]         rd_data;

  // The input is only open while hunting or collecting. Reads of the frame
  // store therefore never meet a write, and no forwarding is needed.
  assign in_stall = !(state inside {ST_HUNT, ST_FRAME});
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  // The output register can take a new word when it is empty or its current
  // word leaves in this cycle.
  assign load_ok  = !out_valid || !out_stall;
  assign is_last  = (word_cnt == LAST_WORD);

  // Word k sits in frame bytes 2+2k (high) and 3+2k (low).
  assign pair_addr = {word_cnt, 1'b0} + 5'd2;

  psfp_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_frame_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (rx_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and the frame store controls.
  always_comb begin
    state_next = state;
    wr_en      = 1'b0;
    wr_addr    = byte_count;
    rd_en      = 1'b0;
    rd_addr    = AW'(pair_addr);
    case (state)
      ST_HUNT: begin
        // Anything but the start byte is dropped without a trace.
        if (in_fire && (rx_byte == START_BYTE)) begin
          wr_en      = 1'b1;
          wr_addr    = '0;
          state_next = ST_FRAME;
        end
      end
      ST_FRAME: begin
        // The second header byte is not checked; every byte is frame data.
        if (in_fire) begin
          wr_en = 1'b1;
          if (byte_count == IDX_LAST) begin
            state_next = ST_READ_HI;
          end
        end
      end
      ST_READ_HI: begin
        rd_en      = 1'b1;
        rd_addr    = AW'(pair_addr);
        state_next = ST_READ_LO;
      end
      ST_READ_LO: begin
        rd_en      = 1'b1;
        rd_addr    = AW'({pair_addr[4:1], 1'b1});
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (load_ok) begin
          state_next = is_last ? ST_HUNT : ST_READ_HI;
        end
      end
      default: begin
        state_next = ST_HUNT;
      end
    endcase
  end

  // Frame counters and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      running_sum <= '0;
      word_cnt    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if ((state == ST_HUNT) && in_fire && (rx_byte == START_BYTE)) begin
        byte_count  <= AW'(1);
        running_sum <= {8'h00, rx_byte};
      end
      if ((state == ST_FRAME) && in_fire) begin
        if (byte_count == IDX_LAST) begin
          // Frame complete: clear for the next one and start the read-out.
          byte_count  <= '0;
          running_sum <= '0;
          word_cnt    <= '0;
        end else begin
          byte_count <= byte_count + AW'(1);
          if (byte_count < IDX_CHK_HI) begin
            running_sum <= running_sum + {8'h00, rx_byte};
          end
        end
      end
      // A new word replaces the one leaving in the same cycle.
      if ((state == ST_LOAD) && load_ok) begin
        out_valid <= 1'b1;
        word_cnt  <= word_cnt + INDEX_W'(1);
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Checksum capture and the result payload.
  always_ff @(posedge clk) begin
    if ((state == ST_FRAME) && in_fire) begin
      if (byte_count == IDX_CHK_HI) begin
        chk_hi <= rx_byte;
      end
      if (byte_count == IDX_LAST) begin
        // The running sum covers every byte before the checksum word here.
        sum_ok <= (running_sum == {chk_hi, rx_byte});
      end
    end
    if (state == ST_READ_LO) begin
      hi_byte <= rd_data;
    end
    if ((state == ST_LOAD) && load_ok) begin
      word_index  <= word_cnt;
      word_value  <= {hi_byte, rd_data};
      checksum_ok <= sum_ok;
      last_word   <= is_last;
    end
  end

  // The input must be held off while the frame store is being read out.
  `PSFP_ASSERT_SAME(a_stall_during_readout,
                    (state == ST_READ_HI) || (state == ST_READ_LO) || (state == ST_LOAD),
                    in_stall)

  // The final byte of a frame starts the read-out from the first word.
  `PSFP_ASSERT_NEXT(a_frame_end_starts_readout,
                    (state == ST_FRAME) && in_fire && (byte_count == IDX_LAST),
                    (state == ST_READ_HI) && (word_cnt == '0))

  // The last marker only ever travels with the final word index.
  `PSFP_ASSERT_SAME(a_last_word_index,
                    out_valid && last_word,
                    word_index == LAST_WORD)

endmodule

`default_nettype wire

/* tb/particle_sensor_frame_parser_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Particle sensor frame parser testbench
// Sends serial bytes through the valid/stall input channel and checks every
// data word on the result channel against a predictor held in the bench.
// Directed frames cover hunting noise, an unchecked second header byte, start
// bytes inside a frame, word extremes and a failed checksum. Random frames
// with random idling on both sides follow.
// ---------------------------------------------------------------------------

module particle_sensor_frame_parser_tb;
  import psfp_pkg::*;

  localparam int          FRAME_BYTES    = 32;
  localparam int          SUM_BYTES      = FRAME_BYTES - 2;
  localparam int          WORDS_PER_FRAME =
    ((FRAME_BYTES - 4) / 2 > MAX_WORDS) ? MAX_WORDS : (FRAME_BYTES - 4) / 2;
  localparam logic [7:0]  SECOND_BYTE    = 8'h4D;
  localparam int          RANDOM_FRAMES  = 3;
  localparam int          SETTLE_CYCLES  = 80;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          REPORT_LIMIT   = 10;

  // One expected data word of a frame.
  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic [15:0]        value;
    logic               sum_ok;
    logic               last;
  } frame_word_t;

  // Every input of the block has a known value from time zero.
  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic [7:0]         rx_byte   = 8'h00;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [INDEX_W-1:0] word_index;
  logic [15:0]        word_value;
  logic               checksum_ok;
  logic               last_word;

  // Predictor state: a copy of the parser's own frame tracking.
  bit                 hunt_open;
  int unsigned        bytes_taken;
  logic [15:0]        byte_sum;
  logic [7:0]         frame_copy [FRAME_BYTES];
  frame_word_t        pending_words [$];

  // Frame contents for the next frame to be sent (bytes 0 to 29).
  logic [7:0]         frame_body [SUM_BYTES];

  // Idling controls, switched per test.
  bit                 sender_idle;
  bit                 receiver_idle;
  int                 stall_left;
  int                 error_count;

  particle_sensor_frame_parser #(
    .FRAME_BYTES(FRAME_BYTES)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .word_index (word_index),
    .word_value (word_value),
    .checksum_ok(checksum_ok),
    .last_word  (last_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap(input bit enabled);
    int roll;
    if (!enabled) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Advances the predictor by one accepted byte. When the final byte of a
  // frame arrives, the frame's data words are queued in order, each with the
  // checksum verdict, and the last of them marked.
  task automatic absorb_byte(input logic [7:0] b);
    logic [15:0] frame_chk;
    logic        match;
    if (!hunt_open) begin
      // While hunting, anything other than the start byte is dropped.
      if (b != START_BYTE) begin
        return;
      end
      hunt_open   = 1'b1;
      bytes_taken = 0;
      byte_sum    = '0;
    end
    frame_copy[bytes_taken] = b;
    if (bytes_taken < SUM_BYTES) begin
      byte_sum = byte_sum + 16'(b);
    end
    bytes_taken++;
    if (bytes_taken < FRAME_BYTES) begin
      return;
    end
    frame_chk = {frame_copy[FRAME_BYTES-2], frame_copy[FRAME_BYTES-1]};
    match     = (byte_sum == frame_chk);
    for (int k = 0; k < WORDS_PER_FRAME; k++) begin
      pending_words.push_back('{idx:    INDEX_W'(k),
                                value:  {frame_copy[2+2*k], frame_copy[3+2*k]},
                                sum_ok: match,
                                last:   (k == WORDS_PER_FRAME - 1)});
    end
    hunt_open   = 1'b0;
    bytes_taken = 0;
    byte_sum    = '0;
  endtask

  // Sends one byte, after an optional gap, and waits for the transaction to
  // complete. We are always just past a rising edge on entry and on return.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap(sender_idle);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    absorb_byte(b);
  endtask

  // Drops valid and holds off until every queued word has been received.
  task automatic wait_for_words();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // Sends frame_body followed by its checksum word, either the true byte sum
  // or a deliberately corrupted one.
  task automatic send_frame(input bit sum_good);
    logic [15:0] chk;
    chk = '0;
    for (int k = 0; k < SUM_BYTES; k++) begin
      chk = chk + 16'(frame_body[k]);
    end
    if (!sum_good) begin
      chk = chk ^ 16'($urandom_range(1, 65535));
    end
    for (int k = 0; k < SUM_BYTES; k++) begin
      send_byte(frame_body[k]);
    end
    send_byte(chk[15:8]);
    send_byte(chk[7:0]);
  endtask

  function automatic logic [7:0] random_data_byte();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      return START_BYTE;
    end else if (roll < 20) begin
      return 8'h00;
    end else if (roll < 30) begin
      return 8'hFF;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == START_BYTE);
    return b;
  endfunction

  // Fills a frame with random content. The second header byte is usually the
  // proper one but is sometimes wrong, which the parser must not care about.
  task automatic fill_random_body();
    frame_body[0] = START_BYTE;
    frame_body[1] = ($urandom_range(0, 3) == 0) ? random_data_byte() : SECOND_BYTE;
    for (int k = 2; k < SUM_BYTES; k++) begin
      frame_body[k] = random_data_byte();
    end
  endtask

  // Result side: checks each completed transaction against the oldest queued
  // word and drives the stall pattern for the next cycle.
  always @(posedge clk) begin
    frame_word_t want;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_words.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("%0t: unexpected word idx=%0d value=%h ok=%b last=%b", $realtime,
                     word_index, word_value, checksum_ok, last_word);
          end
        end else begin
          want = pending_words.pop_front();
          if (word_index !== want.idx || word_value !== want.value ||
              checksum_ok !== want.sum_ok || last_word !== want.last) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
              $display("%0t: word mismatch: expected idx=%0d value=%h ok=%b last=%b",
                       $realtime, want.idx, want.value, want.sum_ok, want.last);
              $display("%0t:                got      idx=%0d value=%h ok=%b last=%b",
                       $realtime, word_index, word_value, checksum_ok, last_word);
            end
          end
        end
      end
      if (stall_left == 0) begin
        stall_left = pick_gap(receiver_idle);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: the run is abandoned if neither channel completes a transaction
  // for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  // Bytes other than the start byte are dropped while hunting.
  task automatic test_hunt_noise();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h41);
    send_byte(8'h43);
    send_byte(SECOND_BYTE);
    send_byte(8'hBD);
  endtask

  // A frame with a wrong second header byte, start bytes in its data and
  // words at both extremes; the checksum is correct.
  task automatic test_good_frame();
    frame_body[0] = START_BYTE;
    frame_body[1] = 8'h00;
    frame_body[2] = 8'hFF;
    frame_body[3] = 8'hFF;
    frame_body[4] = 8'h00;
    frame_body[5] = 8'h00;
    frame_body[6] = START_BYTE;
    frame_body[7] = START_BYTE;
    for (int k = 8; k < SUM_BYTES; k++) begin
      frame_body[k] = 8'(k * 37 + 5);
    end
    send_frame(1'b1);
  endtask

  // A proper header and random content, but the checksum does not match:
  // every word must still arrive, flagged as failed.
  task automatic test_bad_checksum();
    fill_random_body();
    frame_body[1] = SECOND_BYTE;
    send_frame(1'b0);
  endtask

  // Back-to-back transactions with no idling on either side.
  task automatic test_no_idling();
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    fill_random_body();
    send_frame(1'b1);
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
  endtask

  // The sender holds off until the block has delivered every word, then
  // starts the next frame from a fully idle block.
  task automatic test_drain_pause();
    fill_random_body();
    send_frame(1'b1);
    wait_for_words();
    fill_random_body();
    send_frame(1'($urandom_range(0, 1)));
  endtask

  // Mostly well-formed frames with random content, separated by noise; some
  // carry a wrong checksum, and now and then the sender waits for the burst.
  task automatic test_random_frames();
    int noise_len;
    for (int f = 0; f < RANDOM_FRAMES; f++) begin
      noise_len = $urandom_range(0, 4);
      for (int k = 0; k < noise_len; k++) begin
        send_byte(noise_byte());
      end
      fill_random_body();
      send_frame($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0) begin
        wait_for_words();
      end
    end
  endtask

  initial begin
    hunt_open     = 1'b0;
    bytes_taken   = 0;
    byte_sum      = '0;
    error_count   = 0;
    stall_left    = 0;
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_hunt_noise();
    test_good_frame();
    test_bad_checksum();
    test_no_idling();
    test_drain_pause();
    test_random_frames();

    // All bytes are in; let the last burst drain and the block settle.
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (pending_words.size() != 0) begin
      error_count++;
    end
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* particle_sensor_frame_parser.f */
+incdir+hw/rtl
hw/rtl/psfp_pkg.sv
hw/rtl/psfp_ram.sv
hw/rtl/particle_sensor_frame_parser.sv
tb/particle_sensor_frame_parser_tb.sv
